// ===== hw/rtl/tea_pkg.sv =====
// Shared types, constants and helper functions for the TEA block cipher.
// No dependencies; used by the interfaces, the round stage and the top level.
package tea_pkg;

   localparam int WORD_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;
   localparam logic [7:0] TAIL_OFFSET = 8'h40;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [1:0] KEY_CONFIG = 2'd0;
   localparam logic [1:0] KEY_DEFAULT = 2'd1;
   localparam logic [1:0] KEY_LIST = 2'd2;

   // Element [0] is key word 0 (key bytes 0-3, little-endian).
   typedef logic [3:0][WORD_W-1:0] key_type;

   localparam key_type DEFAULT_KEY = {32'hDEAF_1800, 32'hFF24_95C4,
                                      32'hB834_AEF9, 32'h837D_49DE};
   localparam key_type LIST_KEY = {32'h4A32_1CCD, 32'h452B_E7A1,
                                   32'hFA94_1298, 32'h5674_8517};

   typedef struct packed {
      logic              op;
      logic [1:0]        key_select;
      logic              full;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } item_type;

   function automatic key_type select_key(input logic [1:0] sel, input key_type cfg);
      key_type k;
      case (sel)
         KEY_DEFAULT: k = DEFAULT_KEY;
         KEY_LIST:    k = LIST_KEY;
         default:     k = cfg;
      endcase
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v,
                                             input logic [WORD_W-1:0] sum,
                                             input logic [WORD_W-1:0] ka,
                                             input logic [WORD_W-1:0] kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

   // Adds or subtracts the tail offset in the lowest 'lanes' bytes of a word.
   function automatic logic [WORD_W-1:0] adjust_lanes(input logic [WORD_W-1:0] w,
                                                      input logic [2:0] lanes,
                                                      input logic sub);
      logic [WORD_W-1:0] r;
      logic [7:0] b;
      r = w;
      for (int i = 0; i < 4; i++) begin
         b = w[8*i +: 8];
         if (3'(i) < lanes) begin
            r[8*i +: 8] = sub ? (b - TAIL_OFFSET) : (b + TAIL_OFFSET);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/tea_req_if.sv =====
// Request channel: one 8-byte block with its cipher controls.
// Depends on tea_pkg for the word width.
interface tea_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [1:0]                key_select;
   logic [tea_pkg::WORD_W-1:0] block_first;
   logic [tea_pkg::WORD_W-1:0] block_second;
   logic [3:0]                valid_bytes;
   logic                      adjust_tail;

   modport source (output valid, operation, key_select, block_first, block_second,
                   valid_bytes, adjust_tail, input ready);
   modport sink (input valid, operation, key_select, block_first, block_second,
                 valid_bytes, adjust_tail, output ready);
endinterface

// ===== hw/rtl/tea_rsp_if.sv =====
// Response channel: the transformed 8-byte block.
// Depends on tea_pkg for the word width.
interface tea_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tea_pkg::WORD_W-1:0] result_first;
   logic [tea_pkg::WORD_W-1:0] result_second;

   modport source (output valid, result_first, result_second, input ready);
   modport sink (input valid, result_first, result_second, output ready);
endinterface

// ===== hw/rtl/tea_stage.sv =====
// One registered half round of TEA with its own valid bit and flow control.
// Depends on tea_pkg for the item type, key selection and the mix function.
module tea_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  tea_pkg::item_type          in_item,
   output logic                       in_ready,
   output logic                       out_valid,
   output tea_pkg::item_type          out_item,
   input  logic                       out_ready,
   input  tea_pkg::key_type           key_cfg,
   input  logic [tea_pkg::WORD_W-1:0] sum_enc,
   input  logic [tea_pkg::WORD_W-1:0] sum_dec,
   input  logic                       second_half
);

   logic                       valid_ff;
   tea_pkg::item_type          item_ff;
   tea_pkg::item_type          item_in;
   tea_pkg::key_type           key;
   logic [tea_pkg::WORD_W-1:0] sum;
   logic                       update_y;
   logic [tea_pkg::WORD_W-1:0] src;
   logic [tea_pkg::WORD_W-1:0] dst;
   logic [tea_pkg::WORD_W-1:0] ka;
   logic [tea_pkg::WORD_W-1:0] kb;
   logic [tea_pkg::WORD_W-1:0] m;
   logic [tea_pkg::WORD_W-1:0] dst_new;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Encryption updates y then z in each round; decryption updates z then y.
   always_comb begin
      key      = tea_pkg::select_key(in_item.key_select, key_cfg);
      sum      = (in_item.op == tea_pkg::OP_DECRYPT) ? sum_dec : sum_enc;
      update_y = (in_item.op == tea_pkg::OP_DECRYPT) ? second_half : !second_half;
      src      = update_y ? in_item.z : in_item.y;
      dst      = update_y ? in_item.y : in_item.z;
      ka       = update_y ? key[0] : key[2];
      kb       = update_y ? key[1] : key[3];
      m        = tea_pkg::mix(src, sum, ka, kb);
      dst_new  = (in_item.op == tea_pkg::OP_DECRYPT) ? (dst - m) : (dst + m);
      item_in  = in_item;
      if (in_item.full) begin
         if (update_y) begin
            item_in.y = dst_new;
         end else begin
            item_in.z = dst_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hw/rtl/tea_block_cipher_16_round.sv =====
// Top level of the pipelined TEA block cipher with its APB key registers.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and tea_stage.
//
//   Channel   Direction  Handshake           Transaction
//   req       in         valid/ready         one block, controls and byte count
//   rsp       out        valid/ready         one transformed block
//   APB       in         psel/penable/pready one 32-bit key word write or read
//
// An entry register applies the tail adjustment, then 2*ROUNDS half-round
// stages follow, one adder and mix each. A new transaction may enter every
// cycle while the output is not stalled. Each stage has a valid bit and
// fills bubbles while the output is stalled; nothing is dropped or repeated.
// Reset is synchronous and loads the built-in default key.
module tea_block_cipher_16_round #(
   parameter int ROUNDS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   tea_req_if.sink                        req,
   tea_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tea_pkg::WORD_W-1:0]     pwdata,
   output logic [tea_pkg::WORD_W-1:0]     prdata,
   output logic                           pready
);

   localparam int NS = 2 * ROUNDS;

   tea_pkg::key_type  key_ff;
   logic              stage_valid [0:NS];
   tea_pkg::item_type stage_item  [0:NS];
   logic              stage_ready [0:NS+1];
   logic              entry_valid_ff;
   tea_pkg::item_type entry_item_ff;
   tea_pkg::item_type entry_in;
   logic [2:0]        y_lanes;
   logic [2:0]        z_lanes;
   logic              do_adjust;
   logic              subtract;

   // Key registers.
   assign pready = 1'b1;
   assign prdata = key_ff[paddr[3:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= tea_pkg::DEFAULT_KEY;
      end else if (psel && penable && pwrite) begin
         key_ff[paddr[3:2]] <= pwdata;
      end
   end

   // Entry stage. A short block is never ciphered, so its tail adjustment is
   // done here and the round stages pass it through.
   always_comb begin
      y_lanes   = req.valid_bytes[2] ? 3'd4 : req.valid_bytes[2:0];
      z_lanes   = req.valid_bytes[2] ? {1'b0, req.valid_bytes[1:0]} : 3'd0;
      subtract  = (req.operation == tea_pkg::OP_ENCRYPT);
      do_adjust = req.adjust_tail && !req.valid_bytes[3];
      entry_in.op         = req.operation;
      entry_in.key_select = req.key_select;
      entry_in.full       = req.valid_bytes[3];
      entry_in.y          = req.block_first;
      entry_in.z          = req.block_second;
      if (do_adjust) begin
         entry_in.y = tea_pkg::adjust_lanes(req.block_first, y_lanes, subtract);
         entry_in.z = tea_pkg::adjust_lanes(req.block_second, z_lanes, subtract);
      end
   end

   assign stage_ready[0] = !entry_valid_ff || stage_ready[1];
   assign req.ready      = stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (stage_ready[0]) begin
         entry_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0] && req.valid) begin
         entry_item_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_item[0]  = entry_item_ff;

   // Round stages; stage k holds half (k-1)%2 of round (k-1)/2.
   for (genvar k = 1; k <= NS; k++) begin : g_stage
      localparam int R = (k - 1) / 2;
      localparam logic [tea_pkg::WORD_W-1:0] SUM_ENC =
         tea_pkg::TEA_DELTA * 32'(R + 1);
      localparam logic [tea_pkg::WORD_W-1:0] SUM_DEC =
         tea_pkg::TEA_DELTA * 32'(ROUNDS - R);
      localparam logic SECOND = ((k - 1) % 2) == 1;

      tea_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (stage_valid[k-1]),
         .in_item     (stage_item[k-1]),
         .in_ready    (stage_ready[k]),
         .out_valid   (stage_valid[k]),
         .out_item    (stage_item[k]),
         .out_ready   (stage_ready[k+1]),
         .key_cfg     (key_ff),
         .sum_enc     (SUM_ENC),
         .sum_dec     (SUM_DEC),
         .second_half (SECOND)
      );
   end

   assign stage_ready[NS+1] = rsp.ready;
   assign rsp.valid         = stage_valid[NS];
   assign rsp.result_first  = stage_item[NS].y;
   assign rsp.result_second = stage_item[NS].z;

endmodule
